// ===== rtl/dps_pkg.sv =====
// Shared constants and types of the diffuse pixel shader.
// Used by the channel interfaces and by the top level; depends on nothing.
package dps_pkg;

  localparam int unsigned CoordW           = 16;
  localparam int unsigned ColorW           = 8;
  localparam int unsigned MaxLights        = 4;
  localparam int unsigned NumLightsDefault = 4;
  localparam int unsigned LightW           = 49;
  localparam int unsigned FracBits         = 14;
  localparam int unsigned IntensW          = 17;
  localparam int unsigned IntensityMax     = 131071;
  localparam int unsigned UnitOne          = 16384;
  localparam int unsigned GrayLevel        = 128;
  localparam int unsigned Bias             = 5;
  localparam int unsigned ChanMax          = 255;
  localparam int unsigned RegIdxW          = 3;
  localparam int unsigned PaddrW           = 6;
  localparam int unsigned PdataW           = 64;

  typedef enum logic [RegIdxW-1:0] {
    RegTexture = 3'd0,
    RegLight0  = 3'd1,
    RegLight1  = 3'd2,
    RegLight2  = 3'd3,
    RegLight3  = 3'd4
  } reg_idx_e;

endpackage

// ===== rtl/dps_pix_in_if.sv =====
// Input channel of the shader: one fragment (normal and texel) per request.
// Depends on dps_pkg for the field widths.
interface dps_pix_in_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [dps_pkg::CoordW-1:0]    normal_x;
  logic signed [dps_pkg::CoordW-1:0]    normal_y;
  logic signed [dps_pkg::CoordW-1:0]    normal_z;
  logic        [dps_pkg::ColorW-1:0]    texel_red;
  logic        [dps_pkg::ColorW-1:0]    texel_green;
  logic        [dps_pkg::ColorW-1:0]    texel_blue;

  modport source (output valid, normal_x, normal_y, normal_z, texel_red, texel_green,
                  texel_blue, input ready);
  modport sink (input valid, normal_x, normal_y, normal_z, texel_red, texel_green,
                texel_blue, output ready);
endinterface

// ===== rtl/dps_pix_out_if.sv =====
// Output channel of the shader: one shaded color per request.
// Depends on dps_pkg for the field widths.
interface dps_pix_out_if;
  logic                          valid;
  logic                          ready;
  logic [dps_pkg::ColorW-1:0]    red;
  logic [dps_pkg::ColorW-1:0]    green;
  logic [dps_pkg::ColorW-1:0]    blue;

  modport source (output valid, red, green, blue, input ready);
  modport sink (input valid, red, green, blue, output ready);
endinterface

// ===== rtl/diffuse_pixel_shader.sv =====
// Lambert diffuse pixel shader: normalize, per-light dot products, shade.
// Depends on dps_pkg, dps_pix_in_if and dps_pix_out_if.
//
//  channel   direction  handshake          payload
//  pix_i     in         valid/ready        normal_x/y/z, texel_red/green/blue
//  pix_o     out        valid/ready        red, green, blue
//  apb       in         psel/penable/pwr   paddr, pwdata, prdata
//
// One request enters per cycle unless the output stalls; the normalizing root
// search takes 15 restoring steps, one bit per stage.
// Reset clears all valid bits and the registers (texturing off, lights off).
// A stalled output freezes every stage, so nothing is lost or repeated.
module diffuse_pixel_shader #(
  parameter int unsigned NumLights = dps_pkg::NumLightsDefault
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  dps_pix_in_if.sink                   pix_i,
  dps_pix_out_if.source                pix_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [dps_pkg::PaddrW-1:0]   paddr,
  input  logic [dps_pkg::PdataW-1:0]   pwdata,
  output logic [dps_pkg::PdataW-1:0]   prdata,
  output logic                         pready
);

  localparam int unsigned SqrtSteps = 15;

  typedef struct packed {
    logic [31:0]       len;
    logic [2:0][58:0]  rem;
    logic [2:0][47:0]  prod;
    logic [2:0][14:0]  root;
    logic [2:0]        neg;
    logic              zero;
    logic [2:0][7:0]   tex;
  } sq_t;

  // ---------------- configuration registers ----------------
  logic                           tex_en_q;
  logic [dps_pkg::LightW-1:0]     light_q [dps_pkg::MaxLights];
  dps_pkg::reg_idx_e              reg_idx;
  logic                           cfg_wr;

  assign reg_idx = dps_pkg::reg_idx_e'(paddr[5:3]);
  assign cfg_wr  = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tex_en_q <= 1'b0;
      for (int i = 0; i < dps_pkg::MaxLights; i++) light_q[i] <= '0;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        dps_pkg::RegTexture: tex_en_q   <= pwdata[0];
        dps_pkg::RegLight0:  light_q[0] <= pwdata[dps_pkg::LightW-1:0];
        dps_pkg::RegLight1:  light_q[1] <= pwdata[dps_pkg::LightW-1:0];
        dps_pkg::RegLight2:  light_q[2] <= pwdata[dps_pkg::LightW-1:0];
        dps_pkg::RegLight3:  light_q[3] <= pwdata[dps_pkg::LightW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      dps_pkg::RegTexture: prdata = {63'd0, tex_en_q};
      dps_pkg::RegLight0:  prdata = {15'd0, light_q[0]};
      dps_pkg::RegLight1:  prdata = {15'd0, light_q[1]};
      dps_pkg::RegLight2:  prdata = {15'd0, light_q[2]};
      dps_pkg::RegLight3:  prdata = {15'd0, light_q[3]};
      default:             prdata = '0;
    endcase
  end

  // ---------------- pipeline control ----------------
  logic adv;
  logic out_vld_q;

  assign adv         = !out_vld_q || pix_o.ready;
  assign pix_i.ready = adv;

  // ---------------- stage 1: squares ----------------
  logic             s1_vld_q;
  logic [2:0][30:0] s1_sq_q;
  logic [2:0]       s1_neg_q;
  logic [2:0][7:0]  s1_tex_q;
  logic signed [31:0] sqx, sqy, sqz;

  assign sqx = pix_i.normal_x * pix_i.normal_x;
  assign sqy = pix_i.normal_y * pix_i.normal_y;
  assign sqz = pix_i.normal_z * pix_i.normal_z;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_sq_q  <= {sqz[30:0], sqy[30:0], sqx[30:0]};
      s1_neg_q <= {pix_i.normal_z[15], pix_i.normal_y[15], pix_i.normal_x[15]};
      s1_tex_q <= {pix_i.texel_blue, pix_i.texel_green, pix_i.texel_red};
    end
  end

  // ---------------- root search: one quotient bit per stage ----------------
  logic sq_vld_q [SqrtSteps+1];
  sq_t  sq_q     [SqrtSteps+1];
  sq_t  sq_d     [SqrtSteps];
  sq_t  sq_init;

  always_comb begin
    sq_init      = '0;
    sq_init.len  = 32'(s1_sq_q[0]) + 32'(s1_sq_q[1]) + 32'(s1_sq_q[2]);
    sq_init.zero = (sq_init.len == 32'd0);
    sq_init.neg  = s1_neg_q;
    sq_init.tex  = s1_tex_q;
    for (int k = 0; k < 3; k++) sq_init.rem[k] = {s1_sq_q[k], 28'd0};
  end

  // The remainder tracks target - q*q*len and prod tracks q*len, so trying
  // the next bit costs only shifts, one add and one compare.
  for (genvar j = 0; j < SqrtSteps; j++) begin : g_sqrt
    localparam int Bit = SqrtSteps - 1 - j;
    always_comb begin
      logic [63:0] delta;
      sq_d[j] = sq_q[j];
      for (int k = 0; k < 3; k++) begin
        delta = ({16'd0, sq_q[j].prod[k]} << (Bit + 1))
              + ({32'd0, sq_q[j].len} << (2 * Bit));
        if (delta <= {5'd0, sq_q[j].rem[k]}) begin
          sq_d[j].rem[k]  = sq_q[j].rem[k] - delta[58:0];
          sq_d[j].root[k] = sq_q[j].root[k] | (15'd1 << Bit);
          sq_d[j].prod[k] = sq_q[j].prod[k] + ({16'd0, sq_q[j].len} << Bit);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sq_q[0] <= sq_init;
      for (int j = 0; j < SqrtSteps; j++) sq_q[j+1] <= sq_d[j];
    end
  end

  // ---------------- dot products ----------------
  logic signed [31:0] d1_prod_q [NumLights][3];
  logic [NumLights-1:0] d1_en_q;
  logic                 d1_zero_q;
  logic [2:0][7:0]      d1_tex_q;
  logic signed [15:0]   unit_n [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      unit_n[k] = sq_q[SqrtSteps].neg[k] ? -$signed({1'b0, sq_q[SqrtSteps].root[k]})
                                         : $signed({1'b0, sq_q[SqrtSteps].root[k]});
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < NumLights; i++) begin
        d1_en_q[i] <= light_q[i][48];
        for (int k = 0; k < 3; k++) begin
          d1_prod_q[i][k] <= unit_n[k] * $signed(light_q[i][47-16*k -: 16]);
        end
      end
      d1_zero_q <= sq_q[SqrtSteps].zero;
      d1_tex_q  <= sq_q[SqrtSteps].tex;
    end
  end

  // ---------------- light terms ----------------
  logic [17:0]     d2_term_q [NumLights];
  logic [17:0]     term_d    [NumLights];
  logic            d2_zero_q;
  logic [2:0][7:0] d2_tex_q;

  always_comb begin
    for (int i = 0; i < NumLights; i++) begin
      logic signed [33:0] dot;
      logic signed [33:0] ndot;
      dot  = 34'(d1_prod_q[i][0]) + 34'(d1_prod_q[i][1]) + 34'(d1_prod_q[i][2]);
      ndot = -dot;
      term_d[i] = (d1_en_q[i] && !ndot[33] && ndot != 34'sd0) ? ndot[31:14] : 18'd0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < NumLights; i++) d2_term_q[i] <= term_d[i];
      d2_zero_q <= d1_zero_q;
      d2_tex_q  <= d1_tex_q;
    end
  end

  // ---------------- intensity and base color ----------------
  logic [dps_pkg::IntensW-1:0] d3_inten_q;
  logic [2:0][7:0]             d3_base_q;
  logic [19:0]                 term_sum;
  logic [dps_pkg::IntensW-1:0] inten_d;

  always_comb begin
    term_sum = '0;
    for (int i = 0; i < NumLights; i++) term_sum = term_sum + 20'(d2_term_q[i]);
    if (d2_zero_q) begin
      inten_d = '0;
    end else if (term_sum > 20'(dps_pkg::IntensityMax)) begin
      inten_d = dps_pkg::IntensW'(dps_pkg::IntensityMax);
    end else begin
      inten_d = term_sum[dps_pkg::IntensW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      d3_inten_q <= inten_d;
      d3_base_q  <= tex_en_q ? d2_tex_q : {3{8'(dps_pkg::GrayLevel)}};
    end
  end

  // ---------------- shading product ----------------
  logic [2:0][24:0] d4_prod_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) d4_prod_q[k] <= d3_base_q[k] * d3_inten_q;
    end
  end

  // ---------------- output register ----------------
  logic [2:0][7:0] out_q;
  logic [2:0][7:0] chan_d;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      logic [11:0] v;
      v = 12'(d4_prod_q[k][24:14]) + 12'(dps_pkg::Bias);
      chan_d[k] = (v > 12'(dps_pkg::ChanMax)) ? 8'(dps_pkg::ChanMax) : v[7:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) out_q <= chan_d;
  end

  assign pix_o.valid = out_vld_q;
  assign pix_o.red   = out_q[0];
  assign pix_o.green = out_q[1];
  assign pix_o.blue  = out_q[2];

  // ---------------- valid bits ----------------
  logic d1_vld_q, d2_vld_q, d3_vld_q, d4_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      for (int j = 0; j <= SqrtSteps; j++) sq_vld_q[j] <= 1'b0;
      d1_vld_q  <= 1'b0;
      d2_vld_q  <= 1'b0;
      d3_vld_q  <= 1'b0;
      d4_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (adv) begin
      s1_vld_q    <= pix_i.valid;
      sq_vld_q[0] <= s1_vld_q;
      for (int j = 0; j < SqrtSteps; j++) sq_vld_q[j+1] <= sq_vld_q[j];
      d1_vld_q  <= sq_vld_q[SqrtSteps];
      d2_vld_q  <= d1_vld_q;
      d3_vld_q  <= d2_vld_q;
      d4_vld_q  <= d3_vld_q;
      out_vld_q <= d4_vld_q;
    end
  end

  // ---------------- assertions ----------------
  a_stall_freezes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(d2_vld_q) && $stable(sq_vld_q[SqrtSteps]) && $stable(s1_vld_q))
    else $error("pipeline valid bits moved during a stall");

  a_unit_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sq_vld_q[SqrtSteps] && !sq_q[SqrtSteps].zero |->
      sq_q[SqrtSteps].root[0] <= 15'(dps_pkg::UnitOne) &&
      sq_q[SqrtSteps].root[1] <= 15'(dps_pkg::UnitOne) &&
      sq_q[SqrtSteps].root[2] <= 15'(dps_pkg::UnitOne))
    else $error("normalized component exceeds one");

  a_gray_equal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && !tex_en_q |-> out_q[0] == out_q[1] && out_q[1] == out_q[2])
    else $error("gray base produced unequal channels");

  a_bias_floor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> out_q[0] >= 8'(dps_pkg::Bias) && out_q[1] >= 8'(dps_pkg::Bias) &&
      out_q[2] >= 8'(dps_pkg::Bias))
    else $error("channel below bias");

endmodule

// ===== verif/dps_checker.sv =====
// Checker for the diffuse pixel shader: predicts each shaded color from the
// accepted fragments and the register settings, and compares the results.
// Depends on dps_pkg and the two channel interfaces.
`timescale 1ns / 100ps
module dps_checker #(
  parameter int unsigned NumLights = dps_pkg::NumLightsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  dps_pix_in_if.sink  pix_in,
  dps_pix_out_if.sink pix_out,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [dps_pkg::PaddrW-1:0] paddr,
  input  logic [dps_pkg::PdataW-1:0] pwdata,
  input  logic        pready,
  output int          fail_count,
  output int          pending
);

  typedef struct packed {
    logic [dps_pkg::ColorW-1:0] red;
    logic [dps_pkg::ColorW-1:0] green;
    logic [dps_pkg::ColorW-1:0] blue;
  } color_t;

  logic                         texture_on;
  logic [dps_pkg::LightW-1:0]   light_regs [dps_pkg::MaxLights];
  color_t                       color_queue [$];

  // Largest q of 15 bits with q*q*len2 <= a*a*2^28.
  function automatic logic [14:0] unit_mag(logic [15:0] a, logic [63:0] len2);
    logic [63:0] target;
    logic [63:0] t;
    logic [14:0] q;
    target = ({48'd0, a} * {48'd0, a}) << 28;
    q = '0;
    for (int b = 14; b >= 0; b--) begin
      t = {49'd0, q} | (64'd1 << b);
      if (t * t * len2 <= target) q = t[14:0];
    end
    return q;
  endfunction

  function automatic logic signed [31:0] unit_comp(logic signed [15:0] c, logic [63:0] len2);
    logic [15:0] a;
    logic signed [31:0] m;
    a = c[15] ? 16'(-c) : c;
    m = $signed({17'd0, unit_mag(a, len2)});
    return c[15] ? -m : m;
  endfunction

  function automatic logic [7:0] shade_chan(logic [7:0] base, logic [16:0] inten);
    logic [31:0] v;
    v = (({24'd0, base} * {15'd0, inten}) >> dps_pkg::FracBits) + dps_pkg::Bias;
    return (v > dps_pkg::ChanMax) ? 8'(dps_pkg::ChanMax) : v[7:0];
  endfunction

  function automatic color_t shaded_color(logic signed [15:0] x, logic signed [15:0] y,
                                          logic signed [15:0] z, color_t texel);
    logic signed [63:0] sx, sy, sz, dot;
    logic [63:0] len2, sum;
    logic signed [31:0] nx, ny, nz;
    logic [16:0] inten;
    logic [7:0] base_r, base_g, base_b;
    color_t res;
    sx = x; sy = y; sz = z;
    len2 = sx * sx + sy * sy + sz * sz;
    inten = '0;
    if (len2 != 0) begin
      nx = unit_comp(x, len2);
      ny = unit_comp(y, len2);
      nz = unit_comp(z, len2);
      for (int i = 0; i < NumLights && i < dps_pkg::MaxLights; i++) begin
        if (light_regs[i][48]) begin
          dot = 64'(nx) * 64'($signed(light_regs[i][47:32]))
              + 64'(ny) * 64'($signed(light_regs[i][31:16]))
              + 64'(nz) * 64'($signed(light_regs[i][15:0]));
          if (-dot > 0) begin
            sum = {47'd0, inten} + ((-dot) >> dps_pkg::FracBits);
            inten = (sum > dps_pkg::IntensityMax) ? 17'(dps_pkg::IntensityMax) : sum[16:0];
          end
        end
      end
    end
    base_r = texture_on ? texel.red : 8'(dps_pkg::GrayLevel);
    base_g = texture_on ? texel.green : 8'(dps_pkg::GrayLevel);
    base_b = texture_on ? texel.blue : 8'(dps_pkg::GrayLevel);
    res.red = shade_chan(base_r, inten);
    res.green = shade_chan(base_g, inten);
    res.blue = shade_chan(base_b, inten);
    return res;
  endfunction

  assign pending = color_queue.size();

  always @(posedge clk_i or negedge rst_ni) begin
    color_t got, want;
    if (!rst_ni) begin
      texture_on <= 1'b0;
      for (int i = 0; i < dps_pkg::MaxLights; i++) light_regs[i] <= '0;
      fail_count <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (dps_pkg::reg_idx_e'(paddr[5:3]))
          dps_pkg::RegTexture: texture_on <= pwdata[0];
          dps_pkg::RegLight0:  light_regs[0] <= pwdata[dps_pkg::LightW-1:0];
          dps_pkg::RegLight1:  light_regs[1] <= pwdata[dps_pkg::LightW-1:0];
          dps_pkg::RegLight2:  light_regs[2] <= pwdata[dps_pkg::LightW-1:0];
          dps_pkg::RegLight3:  light_regs[3] <= pwdata[dps_pkg::LightW-1:0];
          default: ;
        endcase
      end
      if (pix_in.valid && pix_in.ready)
        color_queue.push_back(shaded_color(pix_in.normal_x, pix_in.normal_y,
            pix_in.normal_z, '{pix_in.texel_red, pix_in.texel_green, pix_in.texel_blue}));
      if (pix_out.valid && pix_out.ready) begin
        got = '{pix_out.red, pix_out.green, pix_out.blue};
        if (color_queue.size() == 0) begin
          $display("%0t: unexpected color, expected none, actual %h", $time, got);
          fail_count <= fail_count + 1;
        end else begin
          want = color_queue.pop_front();
          if (got.red !== want.red || got.green !== want.green || got.blue !== want.blue) begin
            $display("%0t: color mismatch, expected %h, actual %h", $time, want, got);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

// ===== verif/diffuse_pixel_shader_test.sv =====
// Top of the shader testbench: clock, reset, register writes and fragments with
// random idling. Depends on dps_pkg, the interfaces, the shader and dps_checker.
`timescale 1ns / 100ps
module diffuse_pixel_shader_test;

  localparam int WatchdogLimit = 20000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [dps_pkg::PaddrW-1:0] paddr = '0;
  logic [dps_pkg::PdataW-1:0] pwdata = '0;
  logic [dps_pkg::PdataW-1:0] prdata;
  logic pready;
  int fail_count, pending;
  int send_idle_pct, recv_idle_pct;
  int quiet_cycles;

  dps_pix_in_if  pix_in ();
  dps_pix_out_if pix_out ();

  diffuse_pixel_shader DUT (
    .clk_i, .rst_ni, .pix_i(pix_in.sink), .pix_o(pix_out.source),
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  dps_checker checker_inst (
    .clk_i, .rst_ni, .pix_in(pix_in.sink), .pix_out(pix_out.sink),
    .psel, .penable, .pwrite, .paddr, .pwdata, .pready, .fail_count, .pending
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  initial begin
    pix_in.valid = 1'b0;
    pix_in.normal_x = '0; pix_in.normal_y = '0; pix_in.normal_z = '0;
    pix_in.texel_red = '0; pix_in.texel_green = '0; pix_in.texel_blue = '0;
    pix_out.ready = 1'b0;
  end

  // Receiver stalls at random.
  always @(negedge clk_i)
    pix_out.ready <= rst_ni && ($urandom_range(99) >= recv_idle_pct);

  // Any cycle without a transfer on either channel counts toward the limit.
  always @(posedge clk_i) begin
    if ((pix_in.valid && pix_in.ready) || (pix_out.valid && pix_out.ready))
      quiet_cycles <= 0;
    else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WatchdogLimit) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  task automatic write_reg(dps_pkg::reg_idx_e idx, logic [dps_pkg::PdataW-1:0] value);
    @(negedge clk_i);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= dps_pkg::PaddrW'({idx, 3'b000}); pwdata <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  function automatic logic [dps_pkg::LightW-1:0] light_word(logic en, int x, int y, int z);
    return {en, 16'(x), 16'(y), 16'(z)};
  endfunction

  function automatic logic [dps_pkg::LightW-1:0] random_light();
    case ($urandom_range(3))
      0: return {1'($urandom_range(1)), 16'($urandom), 16'($urandom), 16'($urandom)};
      1: return light_word(1'b1, 0, 0, -16384);
      default: return light_word(1'b1, int'($urandom_range(32768)) - 16384,
                                 int'($urandom_range(32768)) - 16384,
                                 -int'($urandom_range(16384)));
    endcase
  endfunction

  // Sends one fragment; valid stays high across back-to-back requests.
  task automatic send_fragment(logic [15:0] x, y, z, logic [7:0] r, g, b);
    while ($urandom_range(99) < send_idle_pct) begin
      pix_in.valid <= 1'b0;
      @(negedge clk_i);
    end
    pix_in.valid <= 1'b1;
    pix_in.normal_x <= x; pix_in.normal_y <= y; pix_in.normal_z <= z;
    pix_in.texel_red <= r; pix_in.texel_green <= g; pix_in.texel_blue <= b;
    @(posedge clk_i);
    while (!pix_in.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic drain();
    pix_in.valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (30) @(negedge clk_i);
  endtask

  task automatic random_fragments(int count);
    logic [15:0] x, y, z;
    for (int n = 0; n < count; n++) begin
      x = 16'($urandom); y = 16'($urandom); z = 16'($urandom);
      // Small normals exercise the coarse end of the normalizing search.
      if ($urandom_range(3) == 0) begin
        x = 16'(int'($urandom_range(8)) - 4);
        y = 16'(int'($urandom_range(8)) - 4);
        z = 16'(int'($urandom_range(8)) - 4);
      end
      send_fragment(x, y, z, 8'($urandom), 8'($urandom), 8'($urandom));
    end
  endtask

  initial begin
    send_idle_pct = 0;
    recv_idle_pct = 0;
    quiet_cycles = 0;
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: default state, then several lights at once, extremes and zero normal.
    send_fragment(16'd0, 16'd0, 16'd100, 8'd255, 8'd0, 8'd7);
    drain();
    write_reg(dps_pkg::RegTexture, 64'd1);
    write_reg(dps_pkg::RegLight0, 64'(light_word(1'b1, 0, 0, -16384)));
    write_reg(dps_pkg::RegLight1, 64'(light_word(1'b1, 16384, 0, 0)));
    write_reg(dps_pkg::RegLight2, 64'(light_word(1'b1, -32768, -32768, -32768)));
    write_reg(dps_pkg::RegLight3, 64'(light_word(1'b0, 0, -16384, 0)));
    write_reg(dps_pkg::reg_idx_e'(3'd7), 64'hFFFF_FFFF_FFFF_FFFF);
    send_fragment(16'd0, 16'd0, 16'd0, 8'd255, 8'd255, 8'd255);
    send_fragment(16'd0, 16'd0, 16'h7FFF, 8'd255, 8'd128, 8'd0);
    send_fragment(16'd0, 16'd0, 16'h8000, 8'd255, 8'd128, 8'd1);
    send_fragment(16'h8000, 16'h8000, 16'h8000, 8'd255, 8'd255, 8'd255);
    send_fragment(16'h7FFF, 16'h7FFF, 16'h7FFF, 8'd200, 8'd100, 8'd50);
    send_fragment(16'h8000, 16'd0, 16'd0, 8'd1, 8'd2, 8'd3);
    send_fragment(16'd1, 16'd1, 16'd1, 8'd255, 8'd255, 8'd255);
    send_fragment(16'hFFFF, 16'hFFFF, 16'hFFFF, 8'd64, 8'd32, 8'd16);
    send_fragment(16'd3, 16'd4, 16'd0, 8'd170, 8'd85, 8'd255);
    drain();
    write_reg(dps_pkg::RegTexture, 64'd0);
    write_reg(dps_pkg::RegLight3, 64'(light_word(1'b1, 32767, 32767, 32767)));
    send_fragment(16'd5, 16'hFFF0, 16'h8000, 8'd9, 8'd9, 8'd9);
    send_fragment(16'h8000, 16'h8000, 16'h8000, 8'd0, 8'd0, 8'd0);
    drain();

    // Random phases, each with fresh register settings.
    for (int phase = 0; phase < 12; phase++) begin
      send_idle_pct = (phase < 4) ? 34 : (phase < 8) ? 76 : 0;
      recv_idle_pct = (phase < 4) ? 76 : (phase < 8) ? 34 : 0;
      write_reg(dps_pkg::RegTexture, 64'($urandom_range(1)));
      write_reg(dps_pkg::RegLight0, 64'(random_light()));
      write_reg(dps_pkg::RegLight1, 64'(random_light()));
      write_reg(dps_pkg::RegLight2, 64'(random_light()));
      write_reg(dps_pkg::RegLight3, 64'(random_light()));
      random_fragments(130);
      drain();
    end

    if (fail_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule
